FILE: rtl/batched_elimination_stack_top_macros.svh
// Assertion macros shared by the checker of the batched elimination stack.
// Depends on nothing; guarded against repeated inclusion.
`ifndef BATCHED_ELIMINATION_STACK_TOP_MACROS_SVH
`define BATCHED_ELIMINATION_STACK_TOP_MACROS_SVH
`define BES_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: rtl/bes_pkg.sv
// Package of the batched elimination stack: sizes, status codes and the null node code.
// Depends on nothing.
package bes_pkg;
   localparam int BatchSlots = 32;
   localparam int PoolNodes = 1024;
   localparam int SlotW = $clog2(BatchSlots);
   localparam int CntW = $clog2(BatchSlots + 1);
   localparam int NodeW = $clog2(PoolNodes);
   localparam int LinkW = $clog2(PoolNodes + 1);
   localparam int ValW = 32;
   localparam logic [1:0] ST_ACK = 2'd0;
   localparam logic [1:0] ST_VALUE = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;
   localparam logic [LinkW-1:0] NullNode = LinkW'(PoolNodes);
endpackage

FILE: rtl/bes_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module bes_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: rtl/bes_free_map.sv
// Free-node bitmap with a lowest-free search, one 32-node word per cycle.
// Depends on bes_pkg.
module bes_free_map (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    search_start,
   output logic                    search_done,
   output logic                    found,
   output logic [bes_pkg::NodeW-1:0] found_node,
   input  logic                    clr_en,
   input  logic [bes_pkg::NodeW-1:0] clr_node,
   input  logic                    set_en,
   input  logic [bes_pkg::NodeW-1:0] set_node
);
   import bes_pkg::*;
   localparam int Words = (PoolNodes + 31) / 32;
   localparam int WW = (Words > 1) ? $clog2(Words) : 1;
   logic [Words*32-1:0] map_ff, map_in;
   logic [WW:0] word_ff, word_in;
   logic busy_ff, busy_in, done_ff, done_in, found_ff, found_in;
   logic [NodeW-1:0] node_ff, node_in;
   logic [31:0] cur;
   logic [4:0] bit_idx;
   logic hit;

   always_comb begin
      cur = map_ff[word_ff[WW-1:0]*32 +: 32];
      hit = 1'b0;
      bit_idx = '0;
      for (int b = 31; b >= 0; b--) begin
         if (cur[b]) begin
            hit = 1'b1;
            bit_idx = 5'(b);
         end
      end
   end

   always_comb begin
      map_in = map_ff;
      if (clr_en) map_in[clr_node] = 1'b0;
      if (set_en) map_in[set_node] = 1'b1;
      busy_in = busy_ff;
      word_in = word_ff;
      done_in = 1'b0;
      found_in = found_ff;
      node_in = node_ff;
      if (search_start) begin
         busy_in = 1'b1;
         word_in = '0;
      end else if (busy_ff) begin
         if (hit) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            found_in = 1'b1;
            node_in = NodeW'({word_ff[WW-1:0], bit_idx});
         end else if (word_ff == (WW+1)'(Words - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            found_in = 1'b0;
         end else begin
            word_in = word_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= (Words*32)'({PoolNodes{1'b1}});
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         word_ff <= '0;
      end else begin
         map_ff <= map_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
         word_ff <= word_in;
      end
      found_ff <= found_in;
      node_ff <= node_in;
   end

   assign search_done = done_ff;
   assign found = found_ff;
   assign found_node = node_ff;
endmodule

FILE: rtl/batched_elimination_stack_top.sv
// Batched elimination stack: collects a batch of pushes and pops, pairs them off,
// links leftovers into a node pool and returns one transaction per slot in order.
// It loads the batch, splits it into push and pop lists, pairs pushes with pops,
// links each leftover push into a free node from the bitmap (ST_FULL if none),
// serves each leftover pop from the pool (ST_EMPTY if none), then issues results.
// Loads resume after the last result issues; synchronous reset frees every node.
module batched_elimination_stack_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_action,
   input  logic [31:0]              req_value,
   input  logic                     req_last,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [5:0]               rsp_slot,
   output logic [1:0]               rsp_status,
   output logic [31:0]              rsp_result_value,
   output logic                     rsp_final_res
);
   import bes_pkg::*;
   localparam logic [3:0] S_LOAD = 4'd0, S_SPLIT = 4'd1, S_SPLIT_W = 4'd2,
      S_ELIM = 4'd3, S_ELIM_W = 4'd4, S_PUSH = 4'd5, S_PUSH_W = 4'd6,
      S_PUSH_S = 4'd7, S_POP = 4'd8, S_POP_W = 4'd9, S_POP_N = 4'd10,
      S_OUT = 4'd11, S_OUT_W = 4'd12, S_OUT_H = 4'd13;
   logic [3:0] st_ff, st_in;
   logic [CntW-1:0] n_ff, n_in, i_ff, i_in, np_ff, np_in, nq_ff, nq_in;
   logic [LinkW-1:0] head_ff, head_in;
   logic [ValW-1:0] val_ff, val_in;
   logic [SlotW-1:0] ps_ff, ps_in;
   logic rv_ff, rv_in, ph_ff, ph_in;
   logic [5:0] rs_ff, rs_in;
   logic [1:0] rst_ff, rst_in;
   logic [31:0] rval_ff, rval_in;
   logic rfin_ff, rfin_in;

   logic ops_we; logic [SlotW-1:0] ops_wa, ops_ra; logic [32:0] ops_wd, ops_rd;
   logic psl_we; logic [SlotW-1:0] psl_wa, psl_ra, psl_wd, psl_rd;
   logic qsl_we; logic [SlotW-1:0] qsl_wa, qsl_ra, qsl_wd, qsl_rd;
   logic ans_we; logic [SlotW-1:0] ans_wa, ans_ra; logic [33:0] ans_wd, ans_rd;
   logic np_we; logic [NodeW-1:0] np_wa, np_ra; logic [31:0] np_wd, np_rd;
   logic nl_we; logic [NodeW-1:0] nl_wa, nl_ra; logic [LinkW-1:0] nl_wd, nl_rd;
   logic fs_start, fs_done, fs_found, fm_clr, fm_set;
   logic [NodeW-1:0] fs_node;
   logic acc;

   bes_ram #(.Width(33), .Depth(BatchSlots)) u_ops (.clock, .wr_en(ops_we),
      .wr_addr(ops_wa), .wr_data(ops_wd), .rd_addr(ops_ra), .rd_data(ops_rd));
   bes_ram #(.Width(SlotW), .Depth(BatchSlots)) u_psl (.clock, .wr_en(psl_we),
      .wr_addr(psl_wa), .wr_data(psl_wd), .rd_addr(psl_ra), .rd_data(psl_rd));
   bes_ram #(.Width(SlotW), .Depth(BatchSlots)) u_qsl (.clock, .wr_en(qsl_we),
      .wr_addr(qsl_wa), .wr_data(qsl_wd), .rd_addr(qsl_ra), .rd_data(qsl_rd));
   bes_ram #(.Width(34), .Depth(BatchSlots)) u_ans (.clock, .wr_en(ans_we),
      .wr_addr(ans_wa), .wr_data(ans_wd), .rd_addr(ans_ra), .rd_data(ans_rd));
   bes_ram #(.Width(32), .Depth(PoolNodes)) u_pay (.clock, .wr_en(np_we),
      .wr_addr(np_wa), .wr_data(np_wd), .rd_addr(np_ra), .rd_data(np_rd));
   bes_ram #(.Width(LinkW), .Depth(PoolNodes)) u_lnk (.clock, .wr_en(nl_we),
      .wr_addr(nl_wa), .wr_data(nl_wd), .rd_addr(nl_ra), .rd_data(nl_rd));
   bes_free_map u_map (.clock, .reset, .search_start(fs_start), .search_done(fs_done),
      .found(fs_found), .found_node(fs_node), .clr_en(fm_clr), .clr_node(fs_node),
      .set_en(fm_set), .set_node(head_ff[NodeW-1:0]));

   assign req_stall = (st_ff != S_LOAD);
   assign acc = req_valid && !req_stall;

   always_comb begin
      st_in = st_ff; n_in = n_ff; i_in = i_ff; np_in = np_ff; nq_in = nq_ff;
      head_in = head_ff; val_in = val_ff; ps_in = ps_ff; ph_in = ph_ff;
      rv_in = rv_ff; rs_in = rs_ff; rst_in = rst_ff; rval_in = rval_ff;
      rfin_in = rfin_ff;
      ops_we = 1'b0; ops_wa = n_ff[SlotW-1:0]; ops_wd = {req_action, req_value};
      ops_ra = i_ff[SlotW-1:0];
      psl_we = 1'b0; psl_wa = np_ff[SlotW-1:0]; psl_wd = ops_ra;
      psl_ra = np_ff[SlotW-1:0] - 1'b1;
      qsl_we = 1'b0; qsl_wa = nq_ff[SlotW-1:0]; qsl_wd = ops_ra;
      qsl_ra = nq_ff[SlotW-1:0] - 1'b1;
      ans_we = 1'b0; ans_wa = psl_rd; ans_wd = {ST_ACK, 32'd0};
      ans_ra = i_ff[SlotW-1:0];
      np_we = 1'b0; np_wa = fs_node; np_wd = val_ff; np_ra = head_ff[NodeW-1:0];
      nl_we = 1'b0; nl_wa = fs_node; nl_wd = head_ff; nl_ra = head_ff[NodeW-1:0];
      fs_start = 1'b0; fm_clr = 1'b0; fm_set = 1'b0;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      unique case (st_ff)
         S_LOAD: begin
            if (acc) begin
               ops_we = 1'b1;
               n_in = n_ff + 1'b1;
               if (req_last || n_ff == CntW'(BatchSlots - 1)) begin
                  st_in = S_SPLIT; i_in = '0; np_in = '0; nq_in = '0;
               end
            end
         end
         S_SPLIT: st_in = S_SPLIT_W;
         S_SPLIT_W: begin
            if (ops_rd[32]) begin
               qsl_we = 1'b1; qsl_wd = i_ff[SlotW-1:0]; nq_in = nq_ff + 1'b1;
            end else begin
               psl_we = 1'b1; psl_wd = i_ff[SlotW-1:0]; np_in = np_ff + 1'b1;
            end
            i_in = i_ff + 1'b1;
            st_in = (i_ff + 1'b1 == n_ff) ? S_ELIM : S_SPLIT;
         end
         S_ELIM: begin
            if (np_ff != '0 && nq_ff != '0) st_in = S_ELIM_W;
            else st_in = S_PUSH;
            ph_in = 1'b0;
         end
         S_ELIM_W: begin
            ops_ra = psl_rd;
            if (!ph_ff) begin
               ph_in = 1'b1;
               ans_we = 1'b1;
            end else begin
               ans_we = 1'b1; ans_wa = qsl_rd; ans_wd = {ST_VALUE, ops_rd[31:0]};
               np_in = np_ff - 1'b1; nq_in = nq_ff - 1'b1; st_in = S_ELIM;
            end
         end
         S_PUSH: begin
            if (np_ff != '0) begin
               st_in = S_PUSH_W; ph_in = 1'b0;
            end else st_in = S_POP;
         end
         S_PUSH_W: begin
            ops_ra = psl_rd;
            if (!ph_ff) begin
               ph_in = 1'b1; fs_start = 1'b1;
            end else begin
               val_in = ops_rd[31:0]; ps_in = psl_rd; st_in = S_PUSH_S;
            end
         end
         S_PUSH_S: begin
            if (fs_done) begin
               ans_we = 1'b1; ans_wa = ps_ff;
               if (fs_found) begin
                  np_we = 1'b1; nl_we = 1'b1; fm_clr = 1'b1;
                  head_in = LinkW'(fs_node);
               end else ans_wd = {ST_FULL, 32'd0};
               np_in = np_ff - 1'b1; st_in = S_PUSH;
            end
         end
         S_POP: begin
            if (nq_ff != '0) st_in = S_POP_W;
            else begin
               st_in = S_OUT; i_in = '0;
            end
         end
         S_POP_W: st_in = S_POP_N;
         S_POP_N: begin
            ans_we = 1'b1; ans_wa = qsl_rd;
            if (head_ff == NullNode) ans_wd = {ST_EMPTY, 32'd0};
            else begin
               ans_wd = {ST_VALUE, np_rd}; fm_set = 1'b1;
               head_in = (nl_rd > NullNode) ? NullNode : nl_rd;
            end
            nq_in = nq_ff - 1'b1; st_in = S_POP;
         end
         S_OUT: st_in = S_OUT_W;
         S_OUT_W: st_in = S_OUT_H;
         S_OUT_H: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1; rs_in = 6'(i_ff); rst_in = ans_rd[33:32];
               rval_in = ans_rd[31:0]; rfin_in = (i_ff + 1'b1 == n_ff);
               i_in = i_ff + 1'b1;
               if (i_ff + 1'b1 == n_ff) begin
                  st_in = S_LOAD; n_in = '0;
               end else st_in = S_OUT;
            end
         end
         default: st_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_LOAD; n_ff <= '0; head_ff <= NullNode; rv_ff <= 1'b0;
         i_ff <= '0; np_ff <= '0; nq_ff <= '0; ph_ff <= 1'b0;
      end else begin
         st_ff <= st_in; n_ff <= n_in; head_ff <= head_in; rv_ff <= rv_in;
         i_ff <= i_in; np_ff <= np_in; nq_ff <= nq_in; ph_ff <= ph_in;
      end
      val_ff <= val_in; ps_ff <= ps_in; rs_ff <= rs_in; rst_ff <= rst_in;
      rval_ff <= rval_in; rfin_ff <= rfin_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_slot = rs_ff;
   assign rsp_status = rst_ff;
   assign rsp_result_value = rval_ff;
   assign rsp_final_res = rfin_ff;
endmodule

FILE: rtl/bes_checker.sv
// Port-level checker for the batched elimination stack and its bind statement.
// Depends on bes_pkg and batched_elimination_stack_top_macros.svh.
`include "batched_elimination_stack_top_macros.svh"
module bes_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [5:0]  rsp_slot,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_result_value,
   input logic        rsp_final_res
);
   import bes_pkg::*;
   `BES_ASSERT_IMP(a_val_zero, clock, reset, rsp_valid && rsp_status != ST_VALUE,
      rsp_result_value == 32'd0)
   `BES_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_slot))
   `BES_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid && !rsp_final_res, req_stall)
   `BES_ASSERT_NEXT(a_slot_up, clock, reset, rsp_valid && !rsp_stall && !rsp_final_res,
      rsp_slot != 6'd0 || !rsp_valid)
endmodule

bind batched_elimination_stack_top bes_checker u_bes_checker (.*);

FILE: tb/sv/tb.sv
// Self-checking testbench of batched_elimination_stack_top: predicts every slot answer
// of each closed batch and compares it with the result channel. Depends on bes_pkg.
module tb;
   import bes_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic OpPush = 1'b0;
   localparam logic OpPop = 1'b1;

   typedef struct packed {
      logic        action;
      logic [31:0] value;
      logic        last;
   } stack_op_type;

   typedef struct packed {
      logic [5:0]  slot;
      logic [1:0]  status;
      logic [31:0] value;
      logic        fin;
   } slot_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_action = 1'b0;
   logic [31:0] req_value = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic [5:0] rsp_slot;
   logic [1:0] rsp_status;
   logic [31:0] rsp_result_value;
   logic rsp_final_res;

   stack_op_type pending_ops[$];
   slot_answer_type awaited_answers[$];
   int mismatches = 0;

   // Shadow copy of the block state.
   logic batch_act[BatchSlots];
   logic [31:0] batch_val[BatchSlots];
   int batch_len = 0;
   logic [31:0] node_val[PoolNodes];
   int node_next[PoolNodes];
   logic [PoolNodes-1:0] node_free = '1;
   int top_node = PoolNodes;

   batched_elimination_stack_top dut (.*);

   always #1 clock = ~clock;

   function automatic int pick_free_node();
      for (int i = 0; i < PoolNodes; i++)
         if (node_free[i]) return i;
      return PoolNodes;
   endfunction

   task automatic combine_op(input stack_op_type op);
      int pushes[$];
      int pops[$];
      int ps, qs, nd;
      logic [1:0] st[BatchSlots];
      logic [31:0] v[BatchSlots];
      slot_answer_type a;
      batch_act[batch_len] = op.action;
      batch_val[batch_len] = op.value;
      batch_len++;
      if (!op.last && batch_len < BatchSlots) return;
      for (int i = 0; i < batch_len; i++)
         if (batch_act[i] == OpPop) pops.push_back(i);
         else pushes.push_back(i);
      while (pushes.size() > 0 && pops.size() > 0) begin
         ps = pushes.pop_back();
         qs = pops.pop_back();
         st[ps] = ST_ACK;
         v[ps] = '0;
         st[qs] = ST_VALUE;
         v[qs] = batch_val[ps];
      end
      while (pushes.size() > 0) begin
         ps = pushes.pop_back();
         nd = pick_free_node();
         v[ps] = '0;
         if (nd >= PoolNodes) begin
            st[ps] = ST_FULL;
         end else begin
            node_val[nd] = batch_val[ps];
            node_next[nd] = top_node;
            top_node = nd;
            node_free[nd] = 1'b0;
            st[ps] = ST_ACK;
         end
      end
      while (pops.size() > 0) begin
         qs = pops.pop_back();
         if (top_node >= PoolNodes) begin
            st[qs] = ST_EMPTY;
            v[qs] = '0;
         end else begin
            st[qs] = ST_VALUE;
            v[qs] = node_val[top_node];
            node_free[top_node] = 1'b1;
            top_node = node_next[top_node];
         end
      end
      for (int i = 0; i < batch_len; i++) begin
         a.slot = 6'(i);
         a.status = st[i];
         a.value = v[i];
         a.fin = (i + 1 == batch_len);
         awaited_answers.push_back(a);
      end
      batch_len = 0;
   endtask

   function automatic int draw_wait(input bit calm);
      return calm ? 0 : $urandom_range(0, 17);
   endfunction

   // Driver.
   int send_gap = 0;
   bit send_calm = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) combine_op('{req_action, req_value, req_last});
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               stack_op_type op;
               op = pending_ops.pop_front();
               req_valid <= 1'b1;
               req_action <= op.action;
               req_value <= op.value;
               req_last <= op.last;
               if ($urandom_range(0, 40) == 0) send_calm = !send_calm;
               send_gap = draw_wait(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor.
   int recv_wait = 0;
   bit recv_calm = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transaction: slot %0d status %0d value %h final %0d",
                           rsp_slot, rsp_status, rsp_result_value, rsp_final_res);
            end else begin
               slot_answer_type e;
               e = awaited_answers.pop_front();
               if (e.slot !== rsp_slot || e.status !== rsp_status ||
                   e.value !== rsp_result_value || e.fin !== rsp_final_res) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected slot %0d status %0d value %h final %0d, %s",
                              e.slot, e.status, e.value, e.fin, $sformatf(
                              "got slot %0d status %0d value %h final %0d", rsp_slot,
                              rsp_status, rsp_result_value, rsp_final_res));
               end
            end
            if ($urandom_range(0, 40) == 0) recv_calm = !recv_calm;
            recv_wait = draw_wait(recv_calm);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic add_op(input logic action, input logic [31:0] value, input logic last);
      pending_ops.push_back('{action, value, last});
   endtask

   task automatic add_batches(input int total, input int pop_pct);
      int n, sent;
      bit close;
      sent = 0;
      while (sent < total) begin
         n = ($urandom_range(0, 9) == 0) ? BatchSlots : $urandom_range(1, 8);
         close = (n < BatchSlots) || $urandom_range(0, 1);
         for (int i = 0; i < n; i++)
            add_op($urandom_range(0, 99) < pop_pct ? OpPop : OpPush, $urandom(),
                   (i == n - 1) ? close : 1'b0);
         sent += n;
      end
   endtask

   task automatic wait_drained();
      while (pending_ops.size() > 0 || awaited_answers.size() > 0 || req_valid)
         @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // Pops on an empty stack, extreme values, and a one-item batch.
      add_op(OpPop, 32'hFFFF_FFFF, 1'b0);
      add_op(OpPop, '0, 1'b1);
      add_op(OpPush, 32'hFFFF_FFFF, 1'b0);
      add_op(OpPush, '0, 1'b0);
      add_op(OpPop, 32'h1234_5678, 1'b1);
      add_op(OpPop, '0, 1'b1);
      add_op(OpPop, '0, 1'b1);
      add_op(OpPush, 32'hA5A5_5A5A, 1'b1);
      // A batch that overflows without last.
      for (int i = 0; i < BatchSlots; i++)
         add_op((i % 3 == 0) ? OpPop : OpPush, $urandom(), 1'b0);
      add_batches(160, 50);
      wait_drained();
      repeat (400) @(posedge clock);
      if (mismatches == 0 && awaited_answers.size() == 0)
         $display("batched_elimination_stack_top regression: pass");
      else
         $display("batched_elimination_stack_top regression: fail");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("batched_elimination_stack_top regression: fail");
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/bes_pkg.sv
rtl/bes_ram.sv
rtl/bes_free_map.sv
rtl/batched_elimination_stack_top.sv
rtl/bes_checker.sv
tb/sv/tb.sv
